// ===== rtl/core/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the stable priority event queue and its cells.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int SYS_W  = 8;
    localparam int RES_W  = 8;
    localparam int STAT_W = 4;
    localparam int PRIO_W = 8;
    localparam int AMT_W  = 16;
    localparam int OCC_W  = 5;
    localparam int CODE_W = 2;

    // Packed with the system id in the lowest bits, as on the stream.
    typedef struct packed {
        logic [AMT_W-1:0]  amount;
        logic [PRIO_W-1:0] priority_val;
        logic [STAT_W-1:0] status_code;
        logic [RES_W-1:0]  resource_id;
        logic [SYS_W-1:0]  system_id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry ev;
    } t_cell_cmd;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        RES_DONE  = 2'd0,
        RES_EMPTY = 2'd1,
        RES_FULL  = 2'd2
    } t_result;

endpackage

// ===== rtl/core/stable_priority_event_queue.sv =====
// ---------------------------------------------------------------------------
// stable_priority_event_queue
// Bounded priority queue of event records held in a shift chain of cells.
// The result beat is registered and appears in the cycle after its beat is accepted.
// Throughput: one push or pop per cycle unless the output stalls; every cell compares and shifts at once.
// The output register holds a result until taken; input stalls only then.
// Reset (synchronous, active low) empties the queue and the output register.
// ---------------------------------------------------------------------------
module stable_priority_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] system_id, [15:8] resource_id, [19:16] status_code,
    // [27:20] priority_req, [43:28] amount, [47:44] zero
    input  logic [47:0] i_s_axis_tdata,
    // [0] command
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_system_id, [15:8] out_resource_id, [19:16] out_status_code,
    // [27:20] out_priority, [43:28] out_amount, [48:44] occupancy, [55:49] zero
    output logic [55:0] o_m_axis_tdata,
    // [1:0] result_code
    output logic [1:0]  o_m_axis_tuser
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_result          r_out_code;
    t_entry           r_out_entry;
    logic [OCC_W-1:0] r_out_occ;

    t_cell_cmd        cell_cmd;
    t_entry           in_entry;
    logic             accept;
    logic             is_pop;
    logic             full;
    logic             empty;
    logic [31:0]      count_ext;

    logic   keep  [QUEUE_DEPTH];
    t_entry entry [QUEUE_DEPTH];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_pop          = (t_cmd'(i_s_axis_tuser[0]) == CMD_POP);
    assign full            = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty           = (r_count == '0);
    assign in_entry        = t_entry'(i_s_axis_tdata[ENTRY_W-1:0]);

    assign cell_cmd.push = accept && !is_pop && !full;
    assign cell_cmd.pop  = accept && is_pop && !empty;
    assign cell_cmd.ev   = in_entry;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic   left_keep;
            t_entry left_entry;
            t_entry right_entry;
            logic   occ;
            if (gi == 0) begin : g_head
                assign left_keep  = 1'b1;
                assign left_entry = in_entry;
            end else begin : g_body
                assign left_keep  = keep[gi-1];
                assign left_entry = entry[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign right_entry = entry[gi];
            end else begin : g_mid
                assign right_entry = entry[gi+1];
            end
            assign occ = (r_count > CNT_W'(gi));
            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cell_cmd),
                .i_occ        (occ),
                .i_left_keep  (left_keep),
                .i_left_entry (left_entry),
                .i_right_entry(right_entry),
                .o_keep       (keep[gi]),
                .o_entry      (entry[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (cell_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (cell_cmd.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_occ   <= count_ext[OCC_W-1:0];
            r_out_entry <= cell_cmd.pop ? entry[0] : '0;
            priority if (is_pop && empty) begin
                r_out_code <= RES_EMPTY;
            end else if (!is_pop && full) begin
                r_out_code <= RES_FULL;
            end else begin
                r_out_code <= RES_DONE;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_code;
    assign o_m_axis_tdata  = {7'd0, r_out_occ, r_out_entry};

    // Concurrent checks.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_cmd.pop |=> r_count == $past(r_count) - 1'b1)
        else $error("pop did not remove one entry");

    a_full_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code == RES_FULL) |-> full)
        else $error("full result reported while queue not full");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code == RES_EMPTY) |-> empty)
        else $error("empty result reported while queue holds entries");

endmodule

// ===== rtl/core/spq_cell.sv =====
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps its entry, takes the new event, or
// shifts in a neighbor's entry on a push or a pop.
// ---------------------------------------------------------------------------
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic              i_occ,
    input  logic              i_left_keep,
    input  spq_pkg::t_entry   i_left_entry,
    input  spq_pkg::t_entry   i_right_entry,
    output logic              o_keep,
    output spq_pkg::t_entry   o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The chain is sorted by descending priority, so the cells that keep
    // their entry on a push form a prefix; equal priorities stay ahead.
    assign o_keep  = i_occ && (r_entry.priority_val >= i_cmd.ev.priority_val);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.push && !o_keep) begin
            n_entry = i_left_keep ? i_cmd.ev : i_left_entry;
        end else if (i_cmd.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
